### src/swjag_pkg.sv
`default_nettype none
package swjag_pkg;

   localparam int MaxJoints    = 32;
   localparam int JointIdxW    = 5;
   localparam int CountW       = 6;
   localparam int OddPhaseBias = 8192;
   localparam int QuarterTurn  = 16384;
   localparam int CsrIdxW      = 3;
   localparam int CsrDataW     = 20;

   localparam logic [CsrIdxW-1:0] REG_OFFSET_EVEN = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_OFFSET_ODD  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_AMP_EVEN    = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_AMP_ODD     = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_RATE_EVEN   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_RATE_ODD    = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_STEP_EVEN   = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_STEP_ODD    = 3'd7;

   typedef struct packed {
      logic [15:0] time_step;
      logic [5:0]  num_joints;
   } req_word_type;

   typedef struct packed {
      logic [4:0]  joint_index;
      logic [15:0] angle;
      logic        last_joint;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] offset_even;
      logic signed [15:0] offset_odd;
      logic [14:0] amp_even;
      logic [14:0] amp_odd;
      logic [19:0] rate_even;
      logic [19:0] rate_odd;
      logic [15:0] step_even;
      logic [15:0] step_odd;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture tick word
      logic advance;   // accumulate phases
      logic start;     // start joint i
      logic div_step;  // one divider bit
      logic calc;      // sequence of compute stages
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic calc_done;
      logic empty;
      logic last;
   } dp_sts_type;

endpackage
`default_nettype wire

### src/swjag_if.sv
`default_nettype none
interface swjag_req_if import swjag_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface swjag_rsp_if import swjag_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

### src/sidewinding_joint_angle_generator.sv
`default_nettype none
// Serpenoid sidewinding joint angle generator. Each accepted req word (time_step,
// num_joints) first advances the even and odd phase accumulators, then emits one rsp
// word per joint in order, last_joint set on the final one; num_joints of zero emits
// nothing and num_joints above 32 is taken as 32. Each joint steps through a start
// state, a 22-step bit-serial taper divider plus its done check, a compute sequence
// of eight stages sharing one multiplier plus its done check, and the output
// handshake, which can stall while rsp ready is low.
// csr writes are taken at any time but must only be made while the block is idle.
module sidewinding_joint_angle_generator import swjag_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   swjag_req_if.sink                req,
   swjag_rsp_if.source              rsp,
   input  wire logic                csr_write,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   csr_type    csr_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.offset_even <= '0;
         csr_ff.offset_odd  <= '0;
         csr_ff.amp_even    <= 15'd11437;
         csr_ff.amp_odd     <= 15'd11437;
         csr_ff.rate_even   <= 20'd41722;
         csr_ff.rate_odd    <= 20'd41722;
         csr_ff.step_even   <= 16'd21845;
         csr_ff.step_odd    <= 16'd21845;
      end else if (csr_write) begin
         case (csr_index)
            REG_OFFSET_EVEN: csr_ff.offset_even <= csr_data[15:0];
            REG_OFFSET_ODD:  csr_ff.offset_odd  <= csr_data[15:0];
            REG_AMP_EVEN:    csr_ff.amp_even    <= csr_data[14:0];
            REG_AMP_ODD:     csr_ff.amp_odd     <= csr_data[14:0];
            REG_RATE_EVEN:   csr_ff.rate_even   <= csr_data;
            REG_RATE_ODD:    csr_ff.rate_odd    <= csr_data;
            REG_STEP_EVEN:   csr_ff.step_even   <= csr_data[15:0];
            REG_STEP_ODD:    csr_ff.step_odd    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   swjag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swjag_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .req_word (req.word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp.word)
   );

endmodule
`default_nettype wire

### src/swjag_datapath.sv
`default_nettype none
module swjag_datapath import swjag_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire csr_type      csr,
   input  wire req_word_type req_word,
   input  wire dp_cmd_type   cmd,
   output dp_sts_type        sts,
   output rsp_word_type      rsp_word
);

   logic [31:0] phase_even_ff, phase_even_in;
   logic [31:0] phase_odd_ff, phase_odd_in;
   logic [15:0] dt_ff;
   logic [CountW-1:0] n_ff;
   logic [CountW-1:0] i_ff, i_in;
   logic [15:0] pe_acc_ff, po_acc_ff;
   // taper divider
   logic [21:0] rem_ff, rem_in;
   logic [21:0] dvd_ff;
   logic [21:0] quo_ff, quo_in;
   logic [4:0]  dcnt_ff;
   // compute pipeline
   logic [3:0]  cs_ff;
   logic [1:0]  q_ff;
   logic [14:0] f_ff;
   logic [15:0] x2_ff, u_ff, w_ff;
   logic [14:0] s_ff;
   logic [16:0] taper_ff;
   logic [14:0] a_ff;
   logic [15:0] m_ff;
   logic [15:0] ang_ff;
   logic [31:0] prod_in;
   logic        odd;
   logic [CountW-1:0] n_eff;

   assign n_eff = (req_word.num_joints > CountW'(MaxJoints)) ?
                  CountW'(MaxJoints) : req_word.num_joints;
   assign odd = i_ff[0];

   always_comb begin
      phase_even_in = phase_even_ff + 32'(csr.rate_even * 36'(dt_ff));
      phase_odd_in  = phase_odd_ff + 32'(csr.rate_odd * 36'(dt_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dt_ff <= req_word.time_step;
         n_ff  <= n_eff;
      end
      if (reset) begin
         phase_even_ff <= '0;
         phase_odd_ff  <= '0;
      end else if (cmd.advance) begin
         phase_even_ff <= phase_even_in;
         phase_odd_ff  <= phase_odd_in;
      end
   end

   // joint phases follow i incrementally
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         i_ff <= '0;
         pe_acc_ff <= phase_even_in[31:16];
         po_acc_ff <= phase_odd_in[31:16] + csr.step_odd
                      + 16'(OddPhaseBias + QuarterTurn);
      end else if (cmd.calc && cs_ff == 4'd8) begin
         i_ff <= i_in;
         if (odd) po_acc_ff <= po_acc_ff + csr.step_odd + csr.step_odd;
         else     pe_acc_ff <= pe_acc_ff + csr.step_even + csr.step_even;
      end
   end
   assign i_in = i_ff + 1'b1;

   // restoring divider: (58982*(i+1) + n/2) / n
   always_comb begin
      logic [22:0] t;
      t = {rem_ff, dvd_ff[21]} - 23'(n_ff);
      if (!t[22]) begin
         rem_in = t[21:0];
         quo_in = {quo_ff[20:0], 1'b1};
      end else begin
         rem_in = {rem_ff[20:0], dvd_ff[21]};
         quo_in = {quo_ff[20:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dvd_ff  <= 22'(16'd58982 * 22'(i_ff + 1'b1)) + 22'(n_ff >> 1);
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[20:0], 1'b0};
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end
   assign sts.div_done = (dcnt_ff == 5'd22);

   // at most one multiply per stage
   always_comb begin
      prod_in = '0;
      case (cs_ff)
         4'd1: prod_in = 32'(f_ff) * 32'(f_ff) + 32'd8192;
         4'd2: prod_in = 32'd2320 * 32'(x2_ff) + 32'd8192;
         4'd3: prod_in = (32'd21024 - 32'(u_ff)) * 32'(x2_ff) + 32'd8192;
         4'd4: prod_in = (32'd51472 - 32'(w_ff)) * 32'(f_ff) + 32'd16384;
         4'd5: prod_in = 32'(odd ? csr.amp_odd : csr.amp_even) * 32'(taper_ff)
                         + 32'd32768;
         4'd6: prod_in = 32'(a_ff) * 32'(s_ff) + 32'd8192;
         default: prod_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cs_ff <= '0;
      end else if (cmd.calc) begin
         cs_ff <= cs_ff + 1'b1;
         case (cs_ff)
            4'd0: begin
               q_ff <= (odd ? po_acc_ff[15:14] : pe_acc_ff[15:14]);
               f_ff <= odd ? (po_acc_ff[14] ? 15'(15'd16384 - po_acc_ff[13:0])
                                            : {1'b0, po_acc_ff[13:0]})
                           : (pe_acc_ff[14] ? 15'(15'd16384 - pe_acc_ff[13:0])
                                            : {1'b0, pe_acc_ff[13:0]});
               taper_ff <= 17'(quo_ff) + 17'd6554;
            end
            4'd1: x2_ff <= prod_in[29:14];
            4'd2: u_ff  <= prod_in[29:14];
            4'd3: w_ff  <= prod_in[29:14];
            4'd4: s_ff  <= prod_in[29:15];
            4'd5: a_ff  <= prod_in[30:16];
            4'd6: m_ff  <= prod_in[29:14];
            4'd7: begin
               logic signed [17:0] r;
               r = 18'(signed'(odd ? csr.offset_odd : csr.offset_even))
                   + (q_ff[1] ? -18'(signed'({2'b0, m_ff})) : 18'(signed'({2'b0, m_ff})));
               if (r > 18'sd32767)       ang_ff <= 16'h7fff;
               else if (r < -18'sd32768) ang_ff <= 16'h8000;
               else                      ang_ff <= r[15:0];
            end
            default: ;
         endcase
      end
   end
   assign sts.calc_done = (cs_ff == 4'd8);

   assign sts.empty = (n_eff == '0);
   assign sts.last  = (i_ff + 1'b1 == n_ff);

   assign rsp_word.joint_index = i_ff[JointIdxW-1:0];
   assign rsp_word.angle       = ang_ff;
   assign rsp_word.last_joint  = sts.last;

endmodule
`default_nettype wire

### src/swjag_ctrl.sv
`default_nettype none
module swjag_ctrl import swjag_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ADV   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_CALC  = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_NEXT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      empty_ff, empty_in;

   always_comb begin
      state_in = state_ff;
      empty_in = empty_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               empty_in = sts.empty;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            state_in = empty_ff ? ST_IDLE : ST_NEXT;
         end
         ST_NEXT: begin
            cmd.start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_CALC;
            else cmd.div_step = 1'b1;
         end
         ST_CALC: begin
            if (sts.calc_done) state_in = ST_OUT;
            else cmd.calc = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.calc = 1'b1;
                  state_in = ST_NEXT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         empty_ff <= empty_in;
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept during output");
   a_out_after_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_CALC)) else $error("output without compute");

endmodule
`default_nettype wire
